### design/bahd_pkg.sv
// Types, constants and helper functions shared by the Basic auth header decoder.
// No dependencies; the front end, queue, back end and top level refer to it by scoped names.
`timescale 1ns / 1ps

package bahd_pkg;

    localparam int HDR_LEN     = 21;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_DECODE = 4'b0100,
        PH_AFTER  = 4'b1000
    } phase_t;

    // One queue entry: either a full group of four sextets or the end of a request
    typedef struct packed {
        logic        is_done;
        logic        found;
        logic [23:0] data;
    } entry_t;

    // Lower-case header text, one character per index
    function automatic logic [7:0] hdr_char(input logic [4:0] idx);
        logic [7:0] ch;
        unique case (idx)
            5'd0:    ch = 8'h61; // a
            5'd1:    ch = 8'h75; // u
            5'd2:    ch = 8'h74; // t
            5'd3:    ch = 8'h68; // h
            5'd4:    ch = 8'h6F; // o
            5'd5:    ch = 8'h72; // r
            5'd6:    ch = 8'h69; // i
            5'd7:    ch = 8'h7A; // z
            5'd8:    ch = 8'h61; // a
            5'd9:    ch = 8'h74; // t
            5'd10:   ch = 8'h69; // i
            5'd11:   ch = 8'h6F; // o
            5'd12:   ch = 8'h6E; // n
            5'd13:   ch = 8'h3A; // :
            5'd14:   ch = 8'h20;
            5'd15:   ch = 8'h62; // b
            5'd16:   ch = 8'h61; // a
            5'd17:   ch = 8'h73; // s
            5'd18:   ch = 8'h69; // i
            5'd19:   ch = 8'h63; // c
            5'd20:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Longest proper border of the first idx header characters
    function automatic logic [4:0] hdr_fallback(input logic [4:0] idx);
        logic [4:0] f;
        unique case (idx)
            5'd9,
            5'd17:   f = 5'd1;
            default: f = 5'd0;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Base64 alphabet; anything else, '=' included, maps to zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] d;
        d = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            d = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            d = 6'd63;
        end
        return d;
    endfunction

endpackage

### design/bahd_if.sv
// Valid/ready channel interfaces for request bytes and decoded results.
// Depends on nothing; used by the front end, back end and top level.
`timescale 1ns / 1ps

interface bahd_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] req_byte;

    modport source (output valid, output req_byte, input ready);
    modport sink   (input valid, input req_byte, output ready);
endinterface

interface bahd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;

    modport source (output valid, output out_byte, output byte_valid,
                    output done_res, output found, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input done_res, input found, output ready);
endinterface

### design/bahd_front.sv
// Front end: takes request bytes, matches the header, skips spaces and packs sextets.
// Pushes one queue entry per full group or per request end. Uses bahd_pkg, bahd_if.
`timescale 1ns / 1ps

module bahd_front #(
    parameter int MAX_VALUE_CHARS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bahd_req_if.sink             req,
    input  logic                 queue_full,
    output logic                 push,
    output bahd_pkg::entry_t     push_entry
);

    localparam int VCW = $clog2(MAX_VALUE_CHARS + 1);

    bahd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]       match_count_reg, match_count_next;
    logic [17:0]      group_sextets_reg, group_sextets_next;
    logic [1:0]       group_position_reg, group_position_next;
    logic [VCW-1:0]   value_count_reg, value_count_next;
    logic             header_seen_reg, header_seen_next;

    logic       accept;
    logic [7:0] c;
    logic [7:0] lc;
    logic [4:0] m;
    logic [4:0] fb;
    logic [4:0] m_new;
    logic       take_val;
    logic [5:0] d;

    assign req.ready = !queue_full;
    assign accept    = req.valid && req.ready;
    assign c         = req.req_byte;
    assign lc        = bahd_pkg::to_lower(c);
    assign d         = bahd_pkg::sextet_of(c);

    // Restart matcher: at most two fallbacks since every border is one character long
    always_comb
    begin
        m  = (match_count_reg > 5'(bahd_pkg::HDR_LEN - 1)) ? 5'd0 : match_count_reg;
        fb = bahd_pkg::hdr_fallback(m);
        if (bahd_pkg::hdr_char(m) == lc)
        begin
            m_new = m + 5'd1;
        end
        else if (fb != 5'd0 && bahd_pkg::hdr_char(fb) == lc)
        begin
            m_new = fb + 5'd1;
        end
        else if (bahd_pkg::hdr_char(5'd0) == lc)
        begin
            m_new = 5'd1;
        end
        else
        begin
            m_new = 5'd0;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        match_count_next    = match_count_reg;
        group_sextets_next  = group_sextets_reg;
        group_position_next = group_position_reg;
        value_count_next    = value_count_reg;
        header_seen_next    = header_seen_reg;
        push                = 1'b0;
        push_entry          = '0;
        take_val            = 1'b0;

        if (accept)
        begin
            if (c == bahd_pkg::CHAR_NUL)
            begin
                push                = 1'b1;
                push_entry.is_done  = 1'b1;
                push_entry.found    = header_seen_reg;
                phase_next          = bahd_pkg::PH_SEARCH;
                match_count_next    = 5'd0;
                group_sextets_next  = 18'd0;
                group_position_next = 2'd0;
                value_count_next    = '0;
                header_seen_next    = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    bahd_pkg::PH_SEARCH:
                    begin
                        if (m_new == 5'(bahd_pkg::HDR_LEN))
                        begin
                            match_count_next = 5'd0;
                            header_seen_next = 1'b1;
                            phase_next       = bahd_pkg::PH_SKIP;
                        end
                        else
                        begin
                            match_count_next = m_new;
                        end
                    end
                    bahd_pkg::PH_SKIP:
                    begin
                        if (c != bahd_pkg::CHAR_SPACE)
                        begin
                            phase_next = bahd_pkg::PH_DECODE;
                            take_val   = 1'b1;
                        end
                    end
                    bahd_pkg::PH_DECODE:
                    begin
                        take_val = 1'b1;
                    end
                    bahd_pkg::PH_AFTER:
                    begin
                        phase_next = bahd_pkg::PH_AFTER;
                    end
                    default:
                    begin
                        phase_next = bahd_pkg::PH_SEARCH;
                    end
                endcase

                if (take_val)
                begin
                    if (c == bahd_pkg::CHAR_CR || c == bahd_pkg::CHAR_LF)
                    begin
                        phase_next = bahd_pkg::PH_AFTER;
                    end
                    else if (value_count_reg < VCW'(MAX_VALUE_CHARS))
                    begin
                        value_count_next = value_count_reg + VCW'(1);
                        if (group_position_reg != 2'd3)
                        begin
                            group_sextets_next  = {group_sextets_reg[11:0], d};
                            group_position_next = group_position_reg + 2'd1;
                        end
                        else
                        begin
                            push                = 1'b1;
                            push_entry.data     = {group_sextets_reg, d};
                            group_sextets_next  = 18'd0;
                            group_position_next = 2'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= bahd_pkg::PH_SEARCH;
            match_count_reg    <= 5'd0;
            group_sextets_reg  <= 18'd0;
            group_position_reg <= 2'd0;
            value_count_reg    <= '0;
            header_seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            match_count_reg    <= match_count_next;
            group_sextets_reg  <= group_sextets_next;
            group_position_reg <= group_position_next;
            value_count_reg    <= value_count_next;
            header_seen_reg    <= header_seen_next;
        end
    end

    a_seen_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bahd_pkg::PH_SEARCH) == !header_seen_reg)
        else $error("header_seen out of step with phase");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        value_count_reg <= VCW'(MAX_VALUE_CHARS))
        else $error("value count past limit");

endmodule

### design/bahd_fifo.sv
// Short register queue of decoded groups and request-end marks between front and back.
// Uses bahd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module bahd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bahd_pkg::entry_t  push_entry,
    input  logic              pop,
    output bahd_pkg::entry_t  head,
    output logic              full,
    output logic              empty
);

    localparam int QD  = bahd_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);

    bahd_pkg::entry_t slots_reg [QD];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;

    assign full  = (count_reg == (QAW+1)'(QD));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

### design/bahd_back.sv
// Back end: unpacks queue entries into one result transfer per cycle while res.ready is high,
// through an output register. Uses bahd_pkg and bahd_if.
`timescale 1ns / 1ps

module bahd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bahd_pkg::entry_t  head,
    input  logic              empty,
    output logic              pop,
    bahd_res_if.source        res
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic        done_res_reg, done_res_next;
    logic        found_reg, found_next;
    logic [15:0] rest_reg, rest_next;
    logic [1:0]  rem_reg, rem_next;
    logic        out_free;

    assign out_free       = !out_valid_reg || res.ready;
    assign res.valid      = out_valid_reg;
    assign res.out_byte   = out_byte_reg;
    assign res.byte_valid = byte_valid_reg;
    assign res.done_res   = done_res_reg;
    assign res.found      = found_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        done_res_next   = done_res_reg;
        found_next      = found_reg;
        rest_next       = rest_reg;
        rem_next        = rem_reg;
        pop             = 1'b0;

        if (out_free)
        begin
            if (rem_reg != 2'd0)
            begin
                // advance through the rest of the group
                out_valid_next  = 1'b1;
                out_byte_next   = rest_reg[15:8];
                byte_valid_next = 1'b1;
                done_res_next   = 1'b0;
                found_next      = 1'b0;
                rest_next       = {rest_reg[7:0], 8'h00};
                rem_next        = rem_reg - 2'd1;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.is_done)
                begin
                    out_byte_next   = 8'h00;
                    byte_valid_next = 1'b0;
                    done_res_next   = 1'b1;
                    found_next      = head.found;
                    rem_next        = 2'd0;
                end
                else
                begin
                    out_byte_next   = head.data[23:16];
                    byte_valid_next = 1'b1;
                    done_res_next   = 1'b0;
                    found_next      = 1'b0;
                    rest_next       = head.data[15:0];
                    rem_next        = 2'd2;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        done_res_reg   <= done_res_next;
        found_reg      <= found_next;
        rest_reg       <= rest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    a_rem_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != 2'd0) |-> (out_valid_reg && byte_valid_reg))
        else $error("group bytes pending without a byte in the output register");

endmodule

### design/basic_auth_header_base64_decoder_top.sv
// Basic auth header decoder: one request byte accepted per cycle while the queue has room.
// A group's first decoded byte is registered in the queue, then in the output register,
// and its other two bytes follow it; a request-end item takes the same path.
// While res_ch is ready, output drains one result per cycle from the 4-entry group queue.
// Asynchronous active-low reset returns matcher, decoder, queue and output to idle.
`timescale 1ns / 1ps

module basic_auth_header_base64_decoder_top #(
    parameter int MAX_VALUE_CHARS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    bahd_req_if.sink    req_ch,
    bahd_res_if.source  res_ch
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;
    bahd_pkg::entry_t push_entry;
    bahd_pkg::entry_t head;

    bahd_front #(
        .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    bahd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    bahd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (queue_empty),
        .pop   (pop),
        .res   (res_ch)
    );

endmodule
